FILE: hw/rtl/htsp_pkg.sv
// Shared constants, types and tables for the helix track state propagator.
`timescale 1ns / 1ps
package htsp_pkg;

   localparam int COORD_W   = 24;
   localparam int TRIG_W    = 18;
   localparam int CHARGE_W  = 2;
   localparam int FIELD_W   = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;
   localparam int BEND_W    = 56;   // |charge*field*0.2998*kappa| magnitude
   localparam int NUM_W     = 18;   // magnitude of a divider numerator
   localparam int QUOT_W    = 24;   // quotient bits resolved by the divider
   localparam int DIV_LAT   = QUOT_W + 2;
   localparam int CORDIC_STEPS_DEFAULT = 18;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHARGE_SIGN    = 2'd0,
      CSR_FIELD_STRENGTH = 2'd1
   } csr_index_type;

   localparam logic [14:0] BEND_Q16       = 15'd19648;     // 0.2998 in Q16
   localparam logic [29:0] INV_TWO_PI_Q32 = 30'd683565276; // 1/(2pi) in Q32
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic signed [CHARGE_W-1:0] CHARGE_RESET = 2'sd1;
   localparam logic signed [FIELD_W-1:0]  FIELD_RESET  = 16'sd16384;
   localparam logic signed [COORD_W-1:0]  SAT_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0]  SAT_MIN = 24'sh800000;

   // atan(2^-i) in binary angle units, 2^32 per turn
   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] r;
      case (i)
         0:  r = 32'h20000000;
         1:  r = 32'h12E4051E;
         2:  r = 32'h09FB385B;
         3:  r = 32'h051111D4;
         4:  r = 32'h028B0D43;
         5:  r = 32'h0145D7E1;
         6:  r = 32'h00A2F61E;
         7:  r = 32'h00517C55;
         8:  r = 32'h0028BE53;
         9:  r = 32'h00145F2F;
         10: r = 32'h000A2F98;
         11: r = 32'h000517CC;
         12: r = 32'h00028BE6;
         13: r = 32'h000145F3;
         14: r = 32'h0000A2FA;
         15: r = 32'h0000517D;
         16: r = 32'h000028BE;
         17: r = 32'h0000145F;
         18: r = 32'h00000A30;
         19: r = 32'h00000518;
         20: r = 32'h0000028C;
         21: r = 32'h00000146;
         22: r = 32'h000000A3;
         23: r = 32'h00000051;
         24: r = 32'h00000029;
         25: r = 32'h00000014;
         26: r = 32'h0000000A;
         27: r = 32'h00000005;
         28: r = 32'h00000003;
         29: r = 32'h00000001;
         30: r = 32'h00000001;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] sat24(input logic signed [63:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > 64'(SAT_MAX)) begin
         r = SAT_MAX;
      end else if (v < 64'(SAT_MIN)) begin
         r = SAT_MIN;
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/htsp_if.sv
// Channel interfaces: track input, propagated result and register writes.
`timescale 1ns / 1ps
interface htsp_req_if import htsp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  start_x;
   logic signed [COORD_W-1:0]  start_mx;
   logic signed [COORD_W-1:0]  start_y;
   logic signed [COORD_W-1:0]  start_my;
   logic signed [COORD_W-1:0]  curvature;
   logic signed [COORD_W-1:0]  from_plane_z;
   logic signed [COORD_W-1:0]  to_plane_z;
   modport source (output valid, start_x, start_mx, start_y, start_my, curvature,
                   from_plane_z, to_plane_z, input ready);
   modport sink   (input valid, start_x, start_mx, start_y, start_my, curvature,
                   from_plane_z, to_plane_z, output ready);
endinterface

interface htsp_rsp_if import htsp_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  end_x;
   logic signed [COORD_W-1:0]  end_mx;
   logic signed [COORD_W-1:0]  end_y;
   logic signed [COORD_W-1:0]  end_my;
   logic signed [COORD_W-1:0]  end_curvature;
   logic signed [TRIG_W-1:0]   cos_term;
   logic signed [TRIG_W-1:0]   sin_term;
   logic signed [COORD_W-1:0]  sin_over_bend;
   logic signed [COORD_W-1:0]  versine_over_bend;
   logic                       divide_error;
   modport source (output valid, end_x, end_mx, end_y, end_my, end_curvature,
                   cos_term, sin_term, sin_over_bend, versine_over_bend,
                   divide_error, input ready);
   modport sink   (input valid, end_x, end_mx, end_y, end_my, end_curvature,
                   cos_term, sin_term, sin_over_bend, versine_over_bend,
                   divide_error, output ready);
endinterface

interface htsp_csr_if import htsp_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_IDX_W-1:0]   index;
   logic [CSR_DAT_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/htsp_bend_div.sv
// Pipelined restoring divider: -(n * 2^44) / p, truncated and saturated.
`timescale 1ns / 1ps
module htsp_bend_div import htsp_pkg::*; (
   input  logic                       clock,
   input  logic                       enable,
   input  logic signed [NUM_W:0]      num,
   input  logic [BEND_W-1:0]          pmag,
   input  logic                       pneg,
   output logic signed [COORD_W-1:0]  quot
);

   localparam int REM_W = NUM_W + 44;
   localparam int CMP_W = BEND_W + QUOT_W;

   logic [REM_W-1:0]   rem_ff [0:QUOT_W];
   logic [QUOT_W-1:0]  q_ff   [0:QUOT_W];
   logic [BEND_W-1:0]  pm_ff  [0:QUOT_W];
   logic               ovf_ff [0:QUOT_W];
   logic               neg_ff [0:QUOT_W];
   logic signed [COORD_W-1:0] quot_ff;

   logic [NUM_W-1:0]   un_in;
   logic               ovf_in;

   // quotient of 2^24 or more saturates in every case
   always_comb begin
      un_in  = num[NUM_W] ? NUM_W'(-num) : num[NUM_W-1:0];
      ovf_in = BEND_W'({un_in, 20'd0}) >= pmag;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= {un_in, 44'd0};
         q_ff[0]   <= '0;
         pm_ff[0]  <= pmag;
         ovf_ff[0] <= ovf_in;
         neg_ff[0] <= (num[NUM_W] == pneg);
      end
   end

   for (genvar j = 0; j < QUOT_W; j++) begin : g_step
      localparam int SH = QUOT_W - 1 - j;
      logic [CMP_W-1:0] rem_ext;
      logic [CMP_W-1:0] div_ext;
      logic             take;
      always_comb begin
         rem_ext = CMP_W'(rem_ff[j]);
         div_ext = CMP_W'(pm_ff[j]) << SH;
         take    = rem_ext >= div_ext;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j+1] <= take ? REM_W'(rem_ext - div_ext) : rem_ff[j];
            q_ff[j+1]   <= {q_ff[j][QUOT_W-2:0], take};
            pm_ff[j+1]  <= pm_ff[j];
            ovf_ff[j+1] <= ovf_ff[j];
            neg_ff[j+1] <= neg_ff[j];
         end
      end
   end

   logic [COORD_W:0] mag;
   always_comb begin
      if (neg_ff[QUOT_W]) begin
         mag = (ovf_ff[QUOT_W] || {1'b0, q_ff[QUOT_W]} > 25'd8388608) ?
               25'd8388608 : {1'b0, q_ff[QUOT_W]};
      end else begin
         mag = (ovf_ff[QUOT_W] || {1'b0, q_ff[QUOT_W]} > 25'd8388607) ?
               25'd8388607 : {1'b0, q_ff[QUOT_W]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quot_ff <= neg_ff[QUOT_W] ? COORD_W'(-mag) : mag[COORD_W-1:0];
      end
   end

   assign quot = quot_ff;

endmodule

FILE: hw/rtl/helix_track_state_propagator_unit.sv
// Top level of the helix track state propagator: fully pipelined step.
//
// Usage:
//   req_ch  - one beat per track step: state (x, mx, y, my, kappa) and the
//             z of the old and new planes.
//   rsp_ch  - one beat per accepted step, in order: projected state, kappa,
//             cos/sin of the turning angle (Q2.16), sin/(kappa*a) and
//             (1-cos)/(kappa*a), and a divide-error flag for zero bend.
//   csr_ch  - register writes (0 charge sign, 1 field); always ready. Write
//             only while no step is in flight.
// Pipeline: five stages of bend/angle multiply and quadrant fold, one per
//   CORDIC rotation, one rounding stage, the 26-stage bit-per-stage divider,
//   then two output multiply/sum stages.
// Throughput: one beat per cycle while the pipeline is not stalled; every
//   stage is a register with its own valid bit.
// Reset: clears all valid bits and loads charge +1, field 16384 (4 T).
// Stall: when a result sits in the output register and rsp_ch.ready is low,
//   the whole pipeline holds, bubbles included; nothing is dropped.
`timescale 1ns / 1ps
module helix_track_state_propagator_unit import htsp_pkg::*; #(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   htsp_req_if.sink   req_ch,
   htsp_rsp_if.source rsp_ch,
   htsp_csr_if.sink   csr_ch
);

   // state that rides along with each beat
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] mx;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] my;
      logic signed [COORD_W-1:0] kappa;
      logic [BEND_W-1:0]         pmag;
      logic                      pneg;
      logic                      err;
      logic signed [TRIG_W-1:0]  cs;
      logic signed [TRIG_W-1:0]  sn;
   } carry_type;

   // ---------------- configuration registers
   logic signed [CHARGE_W-1:0] charge_ff;
   logic signed [FIELD_W-1:0]  field_ff;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         charge_ff <= CHARGE_RESET;
         field_ff  <= FIELD_RESET;
      end else if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_CHARGE_SIGN:    charge_ff <= csr_ch.data[CHARGE_W-1:0];
            CSR_FIELD_STRENGTH: field_ff  <= csr_ch.data[FIELD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- global advance: stall only behind a held result
   logic out_valid_ff;
   logic adv;
   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // ---------------- stage 1: bend coefficient A and dz
   logic signed [17:0] cf_in;
   logic signed [31:0] a_in;
   logic signed [24:0] dz_in;
   carry_type          c1_in;
   logic signed [31:0] a_ff;
   logic signed [24:0] dz_ff;
   carry_type          c1_ff;
   logic               v1_ff;

   always_comb begin
      cf_in = $signed({{16{charge_ff[1]}}, charge_ff}) *
              $signed({{2{field_ff[15]}}, field_ff});
      a_in  = $signed({{14{cf_in[17]}}, cf_in}) * $signed({17'd0, BEND_Q16});
      dz_in = 25'(req_ch.to_plane_z) - 25'(req_ch.from_plane_z);
      c1_in       = '0;
      c1_in.x     = req_ch.start_x;
      c1_in.mx    = req_ch.start_mx;
      c1_in.y     = req_ch.start_y;
      c1_in.my    = req_ch.start_my;
      c1_in.kappa = req_ch.curvature;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff  <= a_in;
         dz_ff <= dz_in;
         c1_ff <= c1_in;
      end
   end

   // ---------------- stage 2: P = A*kappa, D = dz/(2pi) in Q32
   logic signed [BEND_W-1:0] p_in;
   logic signed [54:0]       d_in;
   carry_type                c2_in;
   logic [54:0]              dmag_ff;
   logic                     dneg_ff;
   carry_type                c2_ff;
   logic                     v2_ff;

   always_comb begin
      p_in = $signed({{24{a_ff[31]}}, a_ff}) * $signed({{32{c1_ff.kappa[23]}}, c1_ff.kappa});
      d_in = $signed({{30{dz_ff[24]}}, dz_ff}) * $signed({25'd0, INV_TWO_PI_Q32});
      c2_in      = c1_ff;
      c2_in.pmag = p_in[BEND_W-1] ? BEND_W'(-p_in) : p_in;
      c2_in.pneg = p_in[BEND_W-1];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c2_ff   <= c2_in;
         dmag_ff <= d_in[54] ? 55'(-d_in) : d_in;
         dneg_ff <= d_in[54];
      end
   end

   // ---------------- stage 3: |P|*|D| as four partial products
   logic [55:0] pp00_ff, pp10_ff;
   logic [54:0] pp01_ff, pp11_ff;
   logic        dneg3_ff;
   carry_type   c3_in;
   carry_type   c3_ff;
   logic        v3_ff;

   always_comb begin
      c3_in     = c2_ff;
      c3_in.err = (c2_ff.pmag == '0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp00_ff  <= 56'(c2_ff.pmag[27:0]) * 56'(dmag_ff[27:0]);
         pp01_ff  <= 55'(c2_ff.pmag[27:0]) * 55'(dmag_ff[54:28]);
         pp10_ff  <= 56'(c2_ff.pmag[55:28]) * 56'(dmag_ff[27:0]);
         pp11_ff  <= 55'(c2_ff.pmag[55:28]) * 55'(dmag_ff[54:28]);
         dneg3_ff <= dneg_ff;
         c3_ff    <= c3_in;
      end
   end

   // ---------------- stage 4: sum, round at bit 59, keep the angle bits
   logic [91:0] sum_in;
   logic [31:0] raw_ang_ff;
   logic        ang_neg_ff;
   carry_type   c4_ff;
   logic        v4_ff;

   always_comb begin
      sum_in = 92'(pp00_ff) + (92'(pp01_ff) << 28) + (92'(pp10_ff) << 28) +
               (92'(pp11_ff) << 56) + (92'd1 << 59);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         raw_ang_ff <= sum_in[91:60];
         // angle is -(P*D); negate the magnitude when signs agree
         ang_neg_ff <= (c3_ff.pneg == dneg3_ff);
         c4_ff      <= c3_ff;
      end
   end

   // ---------------- stage 5: fold into [-pi/2, pi/2]
   logic [31:0]        ang_in;
   logic signed [33:0] z0_in;
   logic signed [33:0] zf_in;
   logic               flip_in;

   logic signed [33:0] cx_ff   [0:CORDIC_STEPS];
   logic signed [33:0] cy_ff   [0:CORDIC_STEPS];
   logic signed [33:0] cz_ff   [0:CORDIC_STEPS];
   logic               flip_ff [0:CORDIC_STEPS];
   carry_type          cc_ff   [0:CORDIC_STEPS];
   logic               vc_ff   [0:CORDIC_STEPS];

   always_comb begin
      ang_in  = ang_neg_ff ? (32'd0 - raw_ang_ff) : raw_ang_ff;
      z0_in   = 34'(signed'(ang_in));
      zf_in   = z0_in;
      flip_in = 1'b0;
      if (z0_in > 34'sd1073741824) begin
         zf_in   = z0_in - 34'sd2147483648;
         flip_in = 1'b1;
      end else if (z0_in < -34'sd1073741824) begin
         zf_in   = z0_in + 34'sd2147483648;
         flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cx_ff[0]   <= CORDIC_GAIN_Q30;
         cy_ff[0]   <= '0;
         cz_ff[0]   <= zf_in;
         flip_ff[0] <= flip_in;
         cc_ff[0]   <= c4_ff;
      end
   end

   // ---------------- CORDIC rotations, one per stage
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      localparam logic signed [33:0] ATAN = signed'({2'b00, atan_turns(i)});
      logic signed [33:0] xs, ys;
      always_comb begin
         xs = cx_ff[i] >>> i;
         ys = cy_ff[i] >>> i;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            if (cz_ff[i] >= 0) begin
               cx_ff[i+1] <= cx_ff[i] - ys;
               cy_ff[i+1] <= cy_ff[i] + xs;
               cz_ff[i+1] <= cz_ff[i] - ATAN;
            end else begin
               cx_ff[i+1] <= cx_ff[i] + ys;
               cy_ff[i+1] <= cy_ff[i] - xs;
               cz_ff[i+1] <= cz_ff[i] + ATAN;
            end
            flip_ff[i+1] <= flip_ff[i];
            cc_ff[i+1]   <= cc_ff[i];
         end
      end
   end

   // ---------------- round Q30 -> Q16, undo the fold
   logic signed [33:0] xr_in, yr_in;
   carry_type          cr_in;
   carry_type          cr_ff;
   logic               vr_ff;

   always_comb begin
      xr_in    = (cx_ff[CORDIC_STEPS] + 34'sd8192) >>> 14;
      yr_in    = (cy_ff[CORDIC_STEPS] + 34'sd8192) >>> 14;
      cr_in    = cc_ff[CORDIC_STEPS];
      cr_in.cs = flip_ff[CORDIC_STEPS] ? TRIG_W'(-xr_in) : TRIG_W'(xr_in);
      cr_in.sn = flip_ff[CORDIC_STEPS] ? TRIG_W'(-yr_in) : TRIG_W'(yr_in);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cr_ff <= cr_in;
      end
   end

   // ---------------- bend dividers
   logic signed [NUM_W:0]     num_s, num_v;
   logic signed [COORD_W-1:0] quot_s, quot_v;

   assign num_s = (NUM_W+1)'(cr_ff.sn);
   assign num_v = 19'sd65536 - (NUM_W+1)'(cr_ff.cs);

   htsp_bend_div u_div_sin (
      .clock (clock),
      .enable(adv),
      .num   (num_s),
      .pmag  (cr_ff.pmag),
      .pneg  (cr_ff.pneg),
      .quot  (quot_s)
   );

   htsp_bend_div u_div_versine (
      .clock (clock),
      .enable(adv),
      .num   (num_v),
      .pmag  (cr_ff.pmag),
      .pneg  (cr_ff.pneg),
      .quot  (quot_v)
   );

   carry_type cd_ff [0:DIV_LAT-1];
   logic      vd_ff [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_ff[0] <= cr_ff;
      end
   end

   for (genvar k = 1; k < DIV_LAT; k++) begin : g_div_carry
      always_ff @(posedge clock) begin
         if (adv) begin
            cd_ff[k] <= cd_ff[k-1];
         end
      end
   end

   // ---------------- output stage 1: products
   logic signed [47:0] mxs_ff, myv_ff, mys_ff, mxv_ff;
   logic signed [41:0] mxc_ff, mysn_ff, myc_ff, mxsn_ff;
   logic signed [COORD_W-1:0] s1_ff, v1s_ff;
   carry_type                 cx1_ff;
   logic                      vx1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         mxs_ff  <= 48'(cd_ff[DIV_LAT-1].mx) * 48'(quot_s);
         myv_ff  <= 48'(cd_ff[DIV_LAT-1].my) * 48'(quot_v);
         mys_ff  <= 48'(cd_ff[DIV_LAT-1].my) * 48'(quot_s);
         mxv_ff  <= 48'(cd_ff[DIV_LAT-1].mx) * 48'(quot_v);
         mxc_ff  <= 42'(cd_ff[DIV_LAT-1].mx) * 42'(cd_ff[DIV_LAT-1].cs);
         mysn_ff <= 42'(cd_ff[DIV_LAT-1].my) * 42'(cd_ff[DIV_LAT-1].sn);
         myc_ff  <= 42'(cd_ff[DIV_LAT-1].my) * 42'(cd_ff[DIV_LAT-1].cs);
         mxsn_ff <= 42'(cd_ff[DIV_LAT-1].mx) * 42'(cd_ff[DIV_LAT-1].sn);
         s1_ff   <= quot_s;
         v1s_ff  <= quot_v;
         cx1_ff  <= cd_ff[DIV_LAT-1];
      end
   end

   // ---------------- output stage 2: sums, rounding, saturation
   logic signed [49:0] dx_in, dy_in;
   logic signed [43:0] mxr_in, myr_in;
   logic signed [63:0] ex_in, ey_in;

   always_comb begin
      dx_in  = 50'(mxs_ff) - 50'(myv_ff) + 50'sd128;
      dy_in  = 50'(mys_ff) + 50'(mxv_ff) + 50'sd128;
      mxr_in = 44'(mxc_ff) - 44'(mysn_ff) + 44'sd32768;
      myr_in = 44'(myc_ff) + 44'(mxsn_ff) + 44'sd32768;
      ex_in  = 64'(cx1_ff.x) + 64'(dx_in >>> 8);
      ey_in  = 64'(cx1_ff.y) + 64'(dy_in >>> 8);
   end

   logic signed [COORD_W-1:0] end_x_ff, end_mx_ff, end_y_ff, end_my_ff, end_kappa_ff;
   logic signed [TRIG_W-1:0]  cos_ff, sin_ff;
   logic signed [COORD_W-1:0] sob_ff, vob_ff;
   logic                      err_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         end_mx_ff    <= sat24(64'(mxr_in >>> 16));
         end_my_ff    <= sat24(64'(myr_in >>> 16));
         end_kappa_ff <= cx1_ff.kappa;
         cos_ff       <= cx1_ff.cs;
         sin_ff       <= cx1_ff.sn;
         err_ff       <= cx1_ff.err;
         // zero bend: positions and ratios pinned to full scale
         if (cx1_ff.err) begin
            end_x_ff <= SAT_MAX;
            end_y_ff <= SAT_MAX;
            sob_ff   <= SAT_MAX;
            vob_ff   <= SAT_MAX;
         end else begin
            end_x_ff <= sat24(ex_in);
            end_y_ff <= sat24(ey_in);
            sob_ff   <= s1_ff;
            vob_ff   <= v1s_ff;
         end
      end
   end

   // ---------------- valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         vc_ff[0]     <= 1'b0;
         vr_ff        <= 1'b0;
         vd_ff[0]     <= 1'b0;
         vx1_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_ch.valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         vc_ff[0]     <= v4_ff;
         vr_ff        <= vc_ff[CORDIC_STEPS];
         vd_ff[0]     <= vr_ff;
         vx1_ff       <= vd_ff[DIV_LAT-1];
         out_valid_ff <= vx1_ff;
      end
   end

   for (genvar i = 1; i <= CORDIC_STEPS; i++) begin : g_vc
      always_ff @(posedge clock) begin
         if (reset) begin
            vc_ff[i] <= 1'b0;
         end else if (adv) begin
            vc_ff[i] <= vc_ff[i-1];
         end
      end
   end

   for (genvar k = 1; k < DIV_LAT; k++) begin : g_vd
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[k] <= 1'b0;
         end else if (adv) begin
            vd_ff[k] <= vd_ff[k-1];
         end
      end
   end

   // ---------------- result channel
   assign rsp_ch.valid             = out_valid_ff;
   assign rsp_ch.end_x             = end_x_ff;
   assign rsp_ch.end_mx            = end_mx_ff;
   assign rsp_ch.end_y             = end_y_ff;
   assign rsp_ch.end_my            = end_my_ff;
   assign rsp_ch.end_curvature     = end_kappa_ff;
   assign rsp_ch.cos_term          = cos_ff;
   assign rsp_ch.sin_term          = sin_ff;
   assign rsp_ch.sin_over_bend     = sob_ff;
   assign rsp_ch.versine_over_bend = vob_ff;
   assign rsp_ch.divide_error      = err_ff;

endmodule

FILE: test/tb.sv
// Self-checking testbench for the helix track state propagator unit.
`timescale 1ns / 1ps
module tb;
   import htsp_pkg::*;

   localparam int CLK_HALF    = 6;
   localparam int ROT_STEPS   = (CORDIC_STEPS_DEFAULT > 32) ? 32 : CORDIC_STEPS_DEFAULT;
   localparam int PIPE_DEPTH  = CORDIC_STEPS_DEFAULT + 34;
   localparam int STALL_LIMIT = 20000;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // unmapped register index

   typedef struct {
      logic signed [COORD_W-1:0] x, mx, y, my, kappa, z_from, z_to;
   } track_step_type;

   typedef struct {
      logic signed [COORD_W-1:0] x, mx, y, my, kappa;
      logic signed [TRIG_W-1:0]  cs, sn;
      logic signed [COORD_W-1:0] s_bend, v_bend;
      logic                      div_err;
   } track_proj_type;

   // atan(2^-i), 2^32 per turn
   localparam logic [31:0] ATAN_TURN [32] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000};

   logic clock = 1'b0;
   logic reset = 1'b1;

   htsp_req_if req_ch ();
   htsp_rsp_if rsp_ch ();
   htsp_csr_if csr_ch ();

   helix_track_state_propagator_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   always #(CLK_HALF) clock = ~clock;

   // Shadow copy of the block's registers
   logic signed [CHARGE_W-1:0] charge_q = CHARGE_RESET;
   logic signed [FIELD_W-1:0]  field_q  = FIELD_RESET;

   track_proj_type projected_q[$];
   int  send_idle_pct = 0;
   int  stall_pct     = 0;
   int  errors        = 0;
   int  beats_out     = 0;
   int  err_beats     = 0;
   int  quiet_cycles  = 0;

   function automatic logic signed [63:0] clamp24(input logic signed [63:0] v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // -(n*2^44)/p, truncated toward zero, clamped to 24 bits
   function automatic logic signed [63:0] bend_quotient(input logic signed [63:0] n,
                                                        input logic signed [63:0] p);
      logic [63:0] un, up, q;
      un = (n < 0) ? 64'(-n) : 64'(n);
      up = (p < 0) ? 64'(-p) : 64'(p);
      q  = (un << 44) / up;
      if ((n < 0) == (p < 0)) begin
         if (q > 64'd8388608) q = 64'd8388608;
         return -$signed(q);
      end
      if (q > 64'd8388607) q = 64'd8388607;
      return $signed(q);
   endfunction

   function automatic track_proj_type project_track(input track_step_type t);
      track_proj_type r;
      logic signed [63:0] p, d, z, xr, yr, tmp, cs, sn, s, v, mx, my;
      logic [63:0]  up, ud;
      logic [127:0] prod;
      logic [31:0]  ang;
      logic         flip;
      p  = 64'(charge_q) * 64'(field_q) * 64'sd19648 * 64'(t.kappa);
      d  = (64'(t.z_to) - 64'(t.z_from)) * 64'sd683565276;
      up = (p < 0) ? 64'(-p) : 64'(p);
      ud = (d < 0) ? 64'(-d) : 64'(d);
      // angle magnitude rounded half up at bit 60, then signed
      prod = 128'(up) * 128'(ud) + (128'd1 << 59);
      ang  = prod[91:60];
      if ((p < 0) == (d < 0)) ang = -ang;
      z    = 64'($signed(ang));
      flip = 1'b0;
      if (z > (64'sd1 <<< 30)) begin
         z = z - (64'sd1 <<< 31);
         flip = 1'b1;
      end else if (z < -(64'sd1 <<< 30)) begin
         z = z + (64'sd1 <<< 31);
         flip = 1'b1;
      end
      xr = 64'(CORDIC_GAIN_Q30);
      yr = '0;
      for (int i = 0; i < ROT_STEPS; i++) begin
         if (z >= 0) begin
            tmp = xr - (yr >>> i); yr = yr + (xr >>> i); xr = tmp;
            z   = z - 64'(ATAN_TURN[i]);
         end else begin
            tmp = xr + (yr >>> i); yr = yr - (xr >>> i); xr = tmp;
            z   = z + 64'(ATAN_TURN[i]);
         end
      end
      cs = (xr + 64'sd8192) >>> 14;
      sn = (yr + 64'sd8192) >>> 14;
      if (flip) begin
         cs = -cs;
         sn = -sn;
      end
      mx = 64'(t.mx);
      my = 64'(t.my);
      r.mx = COORD_W'(clamp24((mx * cs - my * sn + 64'sd32768) >>> 16));
      r.my = COORD_W'(clamp24((my * cs + mx * sn + 64'sd32768) >>> 16));
      r.div_err = (p == 0);
      if (r.div_err) begin
         s = 64'sd8388607; v = s;
         r.x = SAT_MAX; r.y = SAT_MAX;
      end else begin
         s = bend_quotient(sn, p);
         v = bend_quotient(64'sd65536 - cs, p);
         r.x = COORD_W'(clamp24(64'(t.x) + ((mx * s - my * v + 64'sd128) >>> 8)));
         r.y = COORD_W'(clamp24(64'(t.y) + ((my * s + mx * v + 64'sd128) >>> 8)));
      end
      r.kappa  = t.kappa;
      r.cs     = cs[TRIG_W-1:0];
      r.sn     = sn[TRIG_W-1:0];
      r.s_bend = s[COORD_W-1:0];
      r.v_bend = v[COORD_W-1:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   initial begin
      req_ch.valid = 1'b0;
      req_ch.start_x = '0;  req_ch.start_mx = '0; req_ch.start_y = '0;
      req_ch.start_my = '0; req_ch.curvature = '0;
      req_ch.from_plane_z = '0; req_ch.to_plane_z = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = '0;
      csr_ch.data  = '0;
      rsp_ch.ready = 1'b0;
   end

   // receiver backpressure, changed on the falling edge
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   // result checker: every accepted beat against the oldest projection
   task automatic check_field(input string name, input logic signed [63:0] exp_v,
                              input logic signed [63:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      track_proj_type e;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         beats_out++;
         if (projected_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result beat, end_x %0d", $time, rsp_ch.end_x);
         end else begin
            e = projected_q.pop_front();
            if (e.div_err) err_beats++;
            check_field("end_x",             64'(e.x),      64'(rsp_ch.end_x));
            check_field("end_mx",            64'(e.mx),     64'(rsp_ch.end_mx));
            check_field("end_y",             64'(e.y),      64'(rsp_ch.end_y));
            check_field("end_my",            64'(e.my),     64'(rsp_ch.end_my));
            check_field("end_curvature",     64'(e.kappa),  64'(rsp_ch.end_curvature));
            check_field("cos_term",          64'(e.cs),     64'(rsp_ch.cos_term));
            check_field("sin_term",          64'(e.sn),     64'(rsp_ch.sin_term));
            check_field("sin_over_bend",     64'(e.s_bend), 64'(rsp_ch.sin_over_bend));
            check_field("versine_over_bend", 64'(e.v_bend),
                        64'(rsp_ch.versine_over_bend));
            check_field("divide_error",      64'(e.div_err), 64'(rsp_ch.divide_error));
         end
      end
   end

   // watchdog: cycles with no beat on any channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t watchdog: no beat for %0d cycles", $time, STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // send one track step; called and returns on a falling edge
   task automatic send_track(input track_step_type t);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid        <= 1'b1;
      req_ch.start_x      <= t.x;
      req_ch.start_mx     <= t.mx;
      req_ch.start_y      <= t.y;
      req_ch.start_my     <= t.my;
      req_ch.curvature    <= t.kappa;
      req_ch.from_plane_z <= t.z_from;
      req_ch.to_plane_z   <= t.z_to;
      do @(posedge clock); while (!req_ch.ready);
      projected_q.push_back(project_track(t));
      @(negedge clock);
   endtask

   // let the pipeline run dry, then idle out its depth
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (projected_q.size() != 0) @(negedge clock);
      repeat (PIPE_DEPTH + 8) @(negedge clock);
   endtask

   // register write; only while drained; returns after dropping valid again
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_CHARGE_SIGN) charge_q = val[CHARGE_W-1:0];
      else if (idx == CSR_FIELD_STRENGTH) field_q = val;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_bend(input int chg, input int fld);
      write_reg(CSR_CHARGE_SIGN, 16'(chg));
      write_reg(CSR_FIELD_STRENGTH, 16'(fld));
   endtask

   // signed value of random bit length, so small steps dominate
   function automatic logic signed [COORD_W-1:0] rand_coord();
      int w;
      logic [31:0] r;
      w = $urandom_range(COORD_W, 1);
      r = $urandom;
      if ($urandom_range(7) == 0) return COORD_W'(r);
      return COORD_W'($signed(r << (32 - w)) >>> (32 - w));
   endfunction

   function automatic track_step_type rand_step();
      track_step_type t;
      t.x = rand_coord();  t.mx = rand_coord();
      t.y = rand_coord();  t.my = rand_coord();
      t.kappa = ($urandom_range(31) == 0) ? '0 : rand_coord();
      t.z_from = rand_coord();
      t.z_to = ($urandom_range(31) == 0) ? t.z_from : rand_coord();
      return t;
   endfunction

   // --------------------------------------------------------------- tests
   task automatic test_directed();
      track_step_type t;
      logic signed [COORD_W-1:0] ext[4];
      ext = '{SAT_MAX, SAT_MIN, 24'sd0, -24'sd1};
      send_idle_pct = 0;
      stall_pct = 0;
      // field extremes in every slot
      for (int i = 0; i < 4; i++) begin
         t = '{ext[i], ext[i], ext[(i+1)%4], ext[(i+2)%4], ext[(i+3)%4],
               ext[(i+2)%4], ext[i]};
         send_track(t);
      end
      // zero curvature: divide error
      t = '{24'sd1000, 24'sd256, -24'sd500, 24'sd128, 24'sd0, 24'sd0, 24'sd4096};
      send_track(t);
      // zero path length with live bend
      t = '{24'sd100, 24'sd256, 24'sd100, -24'sd256, 24'sd4096, 24'sd777, 24'sd777};
      send_track(t);
      // gentle arc, both turning senses
      t = '{24'sd0, 24'sd256, 24'sd0, 24'sd0, 24'sd65536, 24'sd0, 24'sd65536};
      send_track(t);
      t.kappa = -24'sd65536;
      send_track(t);
      // large turns that cross a quarter turn
      t = '{24'sd0, 24'sd1000, 24'sd0, 24'sd1000, 24'sd4000000, -24'sd3000000, 24'sd3000000};
      send_track(t);
      t.kappa = -24'sd4000000;
      send_track(t);
      drain();
      // zero charge, then charge pattern -2, then field extremes
      set_bend(0, 16384);
      t = '{24'sd10, 24'sd20, 24'sd30, 24'sd40, 24'sd50000, 24'sd0, 24'sd9000};
      send_track(t);
      drain();
      set_bend(-2, 32767);
      send_track(t);
      t.kappa = SAT_MIN;
      send_track(t);
      drain();
      set_bend(-1, -32768);
      send_track(t);
      t.kappa = SAT_MAX;
      send_track(t);
      drain();
      set_bend(1, 0);   // zero field also gives zero bend
      send_track(t);
      drain();
      // an unmapped index must leave both registers alone
      set_bend(1, 16384);
      write_reg(CSR_SPARE, 16'hFFFF);
      send_track(t);
      drain();
   endtask

   task automatic test_random_phase(input int chg, input int fld, input int mode,
                                    input int n_items, input bit pause_once);
      set_bend(chg, fld);
      case (mode)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 80; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 80; end
         default: begin send_idle_pct = 27; stall_pct = 27; end
      endcase
      for (int i = 0; i < n_items; i++) begin
         if (pause_once && i == n_items / 2) begin
            req_ch.valid <= 1'b0;
            while (projected_q.size() != 0) @(negedge clock);
         end
         send_track(rand_step());
      end
      drain();
   endtask

   task automatic test_random();
      test_random_phase(1, 16384, 0, 300, 1'b0);
      test_random_phase(-1, -32768, 1, 300, 1'b1);
      test_random_phase(-2, 32767, 2, 300, 1'b0);
      test_random_phase(0, 1234, 3, 150, 1'b0);
      test_random_phase(1, 1, 0, 250, 1'b1);
      test_random_phase(-1, int'($urandom_range(65535)) - 32768, 2, 250, 1'b0);
      test_random_phase(1, int'($urandom_range(65535)) - 32768, 3, 250, 1'b0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random();
      stall_pct = 0;
      $display("Ran directed extremes, zero-bend and charge cases plus random steps over");
      $display("%0d result beats (%0d with divide error) under mixed backpressure.",
               beats_out, err_beats);
      if (errors == 0 && projected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, projected_q.size());
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule
